// ===== sv/pfe_pkg.sv =====
// Shared constants and types of the postfix expression evaluator.
package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_BADDEPTH  = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

endpackage

// ===== sv/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfe_alu.sv =====
// Shared arithmetic unit: registered add, subtract, multiply; iterative signed divide.
module pfe_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  pfe_pkg::op_t               op,
  input  logic [pfe_pkg::DATA_W-1:0] a,
  input  logic [pfe_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [pfe_pkg::DATA_W-1:0] result
);
  import pfe_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_FIX  = 3'b100
  } alu_state_t;

  alu_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                done_r, done_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W:0]     shifted;
  logic [DATA_W:0]     diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          unique case (op)
            OP_ADD: begin
              res_nxt  = a + b;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = a - b;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = a * b;
              done_nxt = 1'b1;
            end
            OP_DIV: begin
              // divide magnitudes, fix the sign at the end
              quo_nxt   = a[DATA_W-1] ? (~a + 1'b1) : a;
              dvs_nxt   = b[DATA_W-1] ? (~b + 1'b1) : b;
              rem_nxt   = '0;
              neg_nxt   = a[DATA_W-1] ^ b[DATA_W-1];
              step_nxt  = STEP_W'(DATA_W - 1);
              state_nxt = A_DIV;
            end
            default: ;
          endcase
        end
      end
      A_DIV: begin
        quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W]};
        rem_nxt = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
        if (step_r == '0) begin
          state_nxt = A_FIX;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      A_FIX: begin
        res_nxt   = neg_r ? (~quo_r + 1'b1) : quo_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    res_r  <= res_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== sv/postfix_expression_evaluator.sv =====
// Top level: character sequencer, operand stack and result register.
//
// Postfix evaluator fed one ASCII character per beat. Digits push onto a
// 16-entry operand stack held in a RAM; + - * / pop two operands and push the
// result; NUL delivers one result beat (value, status) and empties the stack.
// A digit or an ignored character is handled without leaving idle. + - *
// read the operands with two registered RAM reads, then start the shared
// arithmetic unit and wait for its done; / uses the bit-serial divider in
// that unit (32 steps plus a sign fix). A / with a zero right operand ends
// after the operand reads, and an operator that underflows or arrives after
// an error is handled without leaving idle. A NUL waits in a finish state
// for the output register to free up. in_stall is high while an item is in
// progress; a waiting result does not stall items that produce none.
module postfix_expression_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  import pfe_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDB  = 5'b00010,
    S_RDA  = 5'b00100,
    S_EXEC = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [2:0]        err_r, err_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] opb_r, opb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [2:0]        out_status_r, out_status_nxt;

  logic              in_acc;
  logic [7:0]        digit;
  logic              is_digit;
  logic              is_oper;
  op_t               sym_op;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              alu_start;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] next_addr;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign digit    = in_symbol - CH_ZERO;
  assign is_digit = (in_symbol >= CH_ZERO) && (in_symbol <= CH_NINE);
  assign is_oper  = (in_symbol == CH_PLUS) || (in_symbol == CH_MINUS) ||
                    (in_symbol == CH_STAR) || (in_symbol == CH_SLASH);

  always_comb begin
    priority if (in_symbol == CH_PLUS) begin
      sym_op = OP_ADD;
    end else if (in_symbol == CH_MINUS) begin
      sym_op = OP_SUB;
    end else if (in_symbol == CH_STAR) begin
      sym_op = OP_MUL;
    end else begin
      sym_op = OP_DIV;
    end
  end

  assign top_addr  = ADDR_W'(cnt_r - 1'b1);
  assign next_addr = ADDR_W'(cnt_r - 2'd2);

  // Read the top entry by default; the second read fetches the left operand.
  assign ram_raddr = (state_r == S_RDB) ? next_addr : top_addr;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    opb_nxt        = opb_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[ADDR_W-1:0];
    ram_wdata      = DATA_W'(digit);
    alu_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_symbol == CH_NUL) begin
            state_nxt = S_FIN;
          end else if (err_r != ST_OK) begin
            // drop everything up to the terminator
          end else if (is_digit) begin
            if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (is_oper) begin
            if (cnt_r < CNT_W'(2)) begin
              err_nxt = ST_UNDERFLOW;
            end else begin
              op_nxt    = sym_op;
              state_nxt = S_RDB;
            end
          end else begin
            // ignore other characters
          end
        end
      end
      S_RDB: begin
        opb_nxt   = ram_rdata;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        if ((op_r == OP_DIV) && (opb_r == '0)) begin
          err_nxt   = ST_DIVZERO;
          state_nxt = S_IDLE;
        end else begin
          alu_start = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          ram_we    = 1'b1;
          ram_waddr = next_addr;
          ram_wdata = alu_result;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_status_nxt = err_r;
            out_value_nxt  = '0;
          end else if (cnt_r == CNT_W'(1)) begin
            out_status_nxt = ST_OK;
            out_value_nxt  = ram_rdata;
          end else begin
            out_status_nxt = ST_BADDEPTH;
            out_value_nxt  = '0;
          end
          cnt_nxt   = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    opb_r        <= opb_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  pfe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (op_r),
    .a      (ram_rdata),
    .b      (opb_r),
    .done   (alu_done),
    .result (alu_result)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
